// File: sv/direct_mapped_writeback_cache_unit_defines.svh
// Assertion macros for the cache unit
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DMWC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define DMWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/dmwc_pkg.sv
package dmwc_pkg;

   // access modes
   localparam logic [1:0] MODE_READ    = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_PRELOAD = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_LINE_OFFSET = 2'd0;
   localparam logic [1:0] CSR_SET_INDEX   = 2'd1;

   // register reset values and limits
   localparam logic [2:0] LINE_OFFSET_RESET = 3'd4;
   localparam logic [3:0] SET_INDEX_RESET   = 4'd6;
   localparam logic [2:0] LINE_OFFSET_MIN   = 3'd2;
   localparam logic [2:0] LINE_OFFSET_MAX   = 3'd6;
   localparam logic [3:0] SET_INDEX_MAX     = 4'd8;
   localparam logic [4:0] ADDR_BITS         = 5'd16;
   localparam logic [3:0] MAX_ACCESS_BYTES  = 4'd8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [3:0]  access_bytes;
      logic [63:0] write_value;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        hit;
      logic        wrote_back;
      logic        fault;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAG,
      ST_CHECK,
      ST_WB,
      ST_FILL,
      ST_XFER,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic tag_read;
      logic preload;
      logic fault_set;
      logic hit_set;
      logic wb_set;
      logic wb_run;
      logic fill_run;
      logic fill_commit;
      logic xfer_run;
      logic dirty_set;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_last;
      logic [1:0] mode;
      logic       fault;
      logic       hit;
      logic       victim_dirty;
      logic       cnt_last;
   } status_type;

endpackage

// File: sv/dmwc_ctrl.sv
module dmwc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  dmwc_pkg::status_type  status,
   output dmwc_pkg::cmd_type     cmd
);

   dmwc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmwc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmwc_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = dmwc_pkg::ST_IDLE;
         end
         dmwc_pkg::ST_IDLE: begin
            if (req_valid) state_in = dmwc_pkg::ST_TAG;
         end
         dmwc_pkg::ST_TAG: begin
            state_in = dmwc_pkg::ST_CHECK;
         end
         dmwc_pkg::ST_CHECK: begin
            priority if (status.mode == dmwc_pkg::MODE_PRELOAD) state_in = dmwc_pkg::ST_RESP;
            else if (status.mode != dmwc_pkg::MODE_READ &&
                     status.mode != dmwc_pkg::MODE_WRITE) state_in = dmwc_pkg::ST_RESP;
            else if (status.fault) state_in = dmwc_pkg::ST_RESP;
            else if (status.hit) state_in = dmwc_pkg::ST_XFER;
            else if (status.victim_dirty) state_in = dmwc_pkg::ST_WB;
            else state_in = dmwc_pkg::ST_FILL;
         end
         dmwc_pkg::ST_WB: begin
            if (status.cnt_last) state_in = dmwc_pkg::ST_FILL;
         end
         dmwc_pkg::ST_FILL: begin
            if (status.cnt_last) state_in = dmwc_pkg::ST_XFER;
         end
         dmwc_pkg::ST_XFER: begin
            if (status.cnt_last) state_in = dmwc_pkg::ST_RESP;
         end
         dmwc_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = dmwc_pkg::ST_IDLE;
         end
         default: state_in = dmwc_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         dmwc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         dmwc_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         dmwc_pkg::ST_TAG: cmd.tag_read = 1'b1;
         dmwc_pkg::ST_CHECK: begin
            priority if (status.mode == dmwc_pkg::MODE_PRELOAD) cmd.preload = 1'b1;
            else if (status.mode != dmwc_pkg::MODE_READ &&
                     status.mode != dmwc_pkg::MODE_WRITE) cmd.preload = 1'b0;
            else if (status.fault) cmd.fault_set = 1'b1;
            else if (status.hit) cmd.hit_set = 1'b1;
            else if (status.victim_dirty) cmd.wb_set = 1'b1;
            else cmd.wb_set = 1'b0;
         end
         dmwc_pkg::ST_WB: cmd.wb_run = 1'b1;
         dmwc_pkg::ST_FILL: begin
            cmd.fill_run    = 1'b1;
            cmd.fill_commit = status.cnt_last;
         end
         dmwc_pkg::ST_XFER: begin
            cmd.xfer_run  = 1'b1;
            cmd.dirty_set = status.cnt_last && (status.mode == dmwc_pkg::MODE_WRITE);
         end
         dmwc_pkg::ST_RESP: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// File: sv/dmwc_dpath.sv
module dmwc_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  dmwc_pkg::req_type     req_payload,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_wdata,
   input  dmwc_pkg::cmd_type     cmd,
   output dmwc_pkg::status_type  status,
   output dmwc_pkg::rsp_type     rsp_payload
);

   // size registers
   logic [2:0] lob_ff;
   logic [3:0] sib_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lob_ff <= dmwc_pkg::LINE_OFFSET_RESET;
         sib_ff <= dmwc_pkg::SET_INDEX_RESET;
      end else if (csr_write) begin
         if (csr_index == dmwc_pkg::CSR_LINE_OFFSET) lob_ff <= csr_wdata[2:0];
         if (csr_index == dmwc_pkg::CSR_SET_INDEX) sib_ff <= csr_wdata;
      end
   end

   // request register; byte count saturated on the way in
   dmwc_pkg::req_type req_ff;
   logic [3:0]        nb_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
         nb_ff  <= (req_payload.access_bytes > dmwc_pkg::MAX_ACCESS_BYTES) ?
                   dmwc_pkg::MAX_ACCESS_BYTES : req_payload.access_bytes;
      end
   end

   // effective geometry and address split
   logic [2:0]  off;
   logic [3:0]  idxb;
   logic [4:0]  sh;
   logic [6:0]  lsize;
   logic [5:0]  bo;
   logic [7:0]  line;
   logic [15:0] tag;
   logic [15:0] vbase;
   logic [15:0] fbase;

   always_comb begin
      priority if (lob_ff < dmwc_pkg::LINE_OFFSET_MIN) off = dmwc_pkg::LINE_OFFSET_MIN;
      else if (lob_ff > dmwc_pkg::LINE_OFFSET_MAX) off = dmwc_pkg::LINE_OFFSET_MAX;
      else off = lob_ff;
      idxb = (sib_ff > dmwc_pkg::SET_INDEX_MAX) ? dmwc_pkg::SET_INDEX_MAX : sib_ff;
      if ((5'(idxb) + 5'(off)) > dmwc_pkg::ADDR_BITS) idxb = 4'(dmwc_pkg::ADDR_BITS - 5'(off));
      sh    = 5'(idxb) + 5'(off);
      lsize = 7'd1 << off;
      bo    = 6'(req_ff.address & 16'(lsize - 7'd1));
      line  = 8'((req_ff.address >> off) & 16'((9'd1 << idxb) - 9'd1));
      tag   = req_ff.address >> sh;
      fbase = req_ff.address & ~16'(lsize - 7'd1);
   end

   // line state: valid and dirty in flops, tags in a memory
   logic [255:0] valid_ff;
   logic [255:0] dirty_ff;
   logic [15:0]  tag_mem [256];
   logic [15:0]  tag_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         if (cmd.fill_commit) begin
            valid_ff[line] <= 1'b1;
            dirty_ff[line] <= 1'b0;
         end
         if (cmd.dirty_set) dirty_ff[line] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_commit) tag_mem[line] <= tag;
      if (cmd.tag_read) tag_rd_ff <= tag_mem[line];
   end

   assign vbase = (tag_rd_ff << sh) | (16'(line) << off);

   // byte counter shared by writeback, refill and transfer
   logic [6:0] cnt_ff, cnt_in;
   logic       p_vld_ff;
   logic [5:0] p_idx_ff;
   logic [6:0] n_sel;
   logic       run;
   logic       cnt_last;
   logic       issue;

   always_comb begin
      priority if (cmd.wb_run || cmd.fill_run) n_sel = lsize;
      else if (cmd.xfer_run) n_sel = 7'(nb_ff);
      else n_sel = '0;
      run      = cmd.wb_run || cmd.fill_run || cmd.xfer_run;
      cnt_last = (cnt_ff == n_sel);
      issue    = run && !cnt_last;
      cnt_in   = cnt_ff;
      if (run) cnt_in = cnt_last ? 7'd0 : cnt_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         p_vld_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         p_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff <= cnt_ff[5:0];
   end

   // clearing pass over backing memory
   logic [15:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 16'd1;
      end
   end

   // line data memory, one byte a beat
   logic [7:0]  line_mem [16384];
   logic [7:0]  line_rd_ff;
   logic [7:0]  back_rd_ff;
   logic        lw_en;
   logic [13:0] lw_addr;
   logic [7:0]  lw_data;
   logic [13:0] lr_addr;
   logic [5:0]  xfer_pos;

   always_comb begin
      xfer_pos = bo + cnt_ff[5:0];
      lw_en    = 1'b0;
      lw_addr  = {line, p_idx_ff};
      lw_data  = back_rd_ff;
      if (cmd.fill_run && p_vld_ff) begin
         lw_en = 1'b1;
      end else if (cmd.xfer_run && issue && req_ff.mode == dmwc_pkg::MODE_WRITE) begin
         lw_en   = 1'b1;
         lw_addr = {line, xfer_pos};
         lw_data = req_ff.write_value[{cnt_ff[2:0], 3'b000} +: 8];
      end
      lr_addr = cmd.xfer_run ? {line, xfer_pos} : {line, cnt_ff[5:0]};
   end

   always_ff @(posedge clock) begin
      if (lw_en) line_mem[lw_addr] <= lw_data;
      line_rd_ff <= line_mem[lr_addr];
   end

   // backing memory, one byte a beat
   logic [7:0]  back_mem [65536];
   logic        bw_en;
   logic [15:0] bw_addr;
   logic [7:0]  bw_data;
   logic [15:0] br_addr;

   always_comb begin
      bw_en   = 1'b0;
      bw_addr = clr_cnt_ff;
      bw_data = '0;
      priority if (cmd.clear_step) begin
         bw_en = 1'b1;
      end else if (cmd.preload) begin
         bw_en   = 1'b1;
         bw_addr = req_ff.address;
         bw_data = req_ff.write_value[7:0];
      end else if (cmd.wb_run && p_vld_ff) begin
         bw_en   = 1'b1;
         bw_addr = vbase + 16'(p_idx_ff);
         bw_data = line_rd_ff;
      end
      br_addr = fbase + 16'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (bw_en) back_mem[bw_addr] <= bw_data;
      back_rd_ff <= back_mem[br_addr];
   end

   // result register
   dmwc_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_ff <= '0;
      end else begin
         if (cmd.fault_set) rsp_ff.fault <= 1'b1;
         if (cmd.hit_set) rsp_ff.hit <= 1'b1;
         if (cmd.wb_set) rsp_ff.wrote_back <= 1'b1;
         if (cmd.xfer_run && p_vld_ff && req_ff.mode == dmwc_pkg::MODE_READ) begin
            rsp_ff.read_data[{p_idx_ff[2:0], 3'b000} +: 8] <= line_rd_ff;
         end
      end
   end

   assign rsp_payload = rsp_ff;

   // status back to the controller
   always_comb begin
      status.clr_last     = &clr_cnt_ff;
      status.mode         = req_ff.mode;
      status.fault        = (7'(bo) + 7'(nb_ff)) > lsize;
      status.hit          = valid_ff[line] && (tag_rd_ff == tag);
      status.victim_dirty = valid_ff[line] && dirty_ff[line];
      status.cnt_last     = cnt_last;
   end

endmodule

// File: sv/direct_mapped_writeback_cache_unit.sv
// channel   | handshake            | beat
// ----------+----------------------+------------------------------------------
// req       | req_valid/req_stall  | mode, address, access_bytes, write_value
// rsp       | rsp_valid/rsp_stall  | read_data, hit, wrote_back, fault
// csr       | csr_valid/csr_ready  | csr_index, csr_wdata (ready always high)
//
// One item at a time. Preload, fault or unused mode go straight to the result.
// A hit transfers the requested bytes; a clean miss refills the line first, and
// a dirty miss writes the victim line back before the refill (byte-wide memory ports).
// After reset a clearing pass zeroes the whole backing memory; req_stall stays high
// meanwhile. The result is held until rsp_stall is low.
`include "direct_mapped_writeback_cache_unit_defines.svh"

module direct_mapped_writeback_cache_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dmwc_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dmwc_pkg::rsp_type   rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [3:0]          csr_wdata
);

   dmwc_pkg::cmd_type    cmd;
   dmwc_pkg::status_type status;

   assign csr_ready = 1'b1;

   dmwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dmwc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // a faulted access reports nothing else
   `DMWC_ASSERT_NOW(a_fault_alone, clock, reset, rsp_valid && rsp_payload.fault, !rsp_payload.hit && !rsp_payload.wrote_back && rsp_payload.read_data == 64'd0, "fault with other result bits")

   // a hit never writes back
   `DMWC_ASSERT_NOW(a_hit_no_wb, clock, reset, rsp_valid && rsp_payload.hit, !rsp_payload.wrote_back, "hit with writeback")

   // no new request while a result waits
   `DMWC_ASSERT_NOW(a_one_item, clock, reset, rsp_valid, req_stall, "request taken while result pending")

   // an accepted request never answers in the next cycle
   `DMWC_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !rsp_valid, "result too early")

endmodule
